### design/hdurb_pkg.sv
package hdurb_pkg;

    localparam int DATA_W = 8;
    localparam int TICKS_W = 16;
    localparam int CMD_W = 3;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [TICKS_W-1:0] TURNAROUND_RESET = 16'd250;

    localparam logic [CMD_W-1:0] CMD_RX_BYTE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOST_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TX_READY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

    typedef struct packed {
        logic latch;
        logic exec;
    } hdurb_cmd_t;

    typedef struct packed {
        logic out_free;
    } hdurb_stat_t;

endpackage

### design/hdurb_ram.sv
module hdurb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/hdurb_ctrl.sv
module hdurb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  hdurb_pkg::hdurb_stat_t stat,
    output hdurb_pkg::hdurb_cmd_t  cmd
);

    import hdurb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    // Accept in idle; execute once the result register can take the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && in_ready_reg)
                    begin
                        state_reg    <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (stat.out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready  = in_ready_reg;
    assign cmd.latch = s_tvalid && in_ready_reg;
    assign cmd.exec  = (state_reg == ST_EXEC) && stat.out_free;

endmodule

### design/hdurb_dp.sv
module hdurb_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hdurb_pkg::hdurb_cmd_t                cmd,
    output hdurb_pkg::hdurb_stat_t               stat,
    input  logic [hdurb_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [hdurb_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hdurb_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    input  logic [hdurb_pkg::TICKS_W-1:0]        cfg_data
);

    import hdurb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);

    logic [CMD_W-1:0]   cmd_reg;
    logic [DATA_W-1:0]  byte_reg;
    logic [TICKS_W-1:0] ticks_reg;

    logic [PW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic          sending_reg, sending_next;
    logic          driver_reg, driver_next;
    logic [TICKS_W-1:0] turn_reg, turn_next;

    logic [DATA_W-1:0] rx_rdata, tx_rdata;
    logic              rx_we, tx_we;

    logic [PW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
    logic [DATA_W-1:0] rd_data, lb;
    logic              lb_valid, rx_ovf, tx_ovf;
    logic [PW:0]       rx_fill;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        ring_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign rx_head_inc = ring_inc(rx_head_reg);
    assign rx_tail_inc = ring_inc(rx_tail_reg);
    assign tx_head_inc = ring_inc(tx_head_reg);
    assign tx_tail_inc = ring_inc(tx_tail_reg);

    // Reads always address the tails; data is fresh by the execute cycle.
    hdurb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (byte_reg),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    hdurb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (byte_reg),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        sending_next = sending_reg;
        driver_next  = driver_reg;
        turn_next    = turn_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rd_data      = '0;
        lb           = '0;
        lb_valid     = 1'b0;
        rx_ovf       = 1'b0;
        tx_ovf       = 1'b0;
        case (cmd_reg)
            CMD_RX_BYTE:
            begin
                if (rx_head_inc != rx_tail_reg)
                begin
                    rx_we        = cmd.exec;
                    rx_head_next = rx_head_inc;
                end
                else
                begin
                    rx_ovf = 1'b1;
                end
            end
            CMD_HOST_WRITE:
            begin
                if (tx_head_inc != tx_tail_reg)
                begin
                    tx_we        = cmd.exec;
                    tx_head_next = tx_head_inc;
                    driver_next  = 1'b1;
                    sending_next = 1'b1;
                    turn_next    = '0;
                end
                else
                begin
                    tx_ovf = 1'b1;
                end
            end
            CMD_HOST_READ:
            begin
                if (rx_tail_reg != rx_head_reg)
                begin
                    rd_data      = rx_rdata;
                    rx_tail_next = rx_tail_inc;
                end
            end
            CMD_TX_READY:
            begin
                if (sending_reg)
                begin
                    if (tx_tail_reg != tx_head_reg)
                    begin
                        lb           = tx_rdata;
                        lb_valid     = 1'b1;
                        tx_tail_next = tx_tail_inc;
                    end
                    else
                    begin
                        sending_next = 1'b0;
                        if (ticks_reg == '0)
                        begin
                            driver_next = 1'b0;
                        end
                        else
                        begin
                            turn_next = ticks_reg;
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (turn_reg != '0)
                begin
                    turn_next = turn_reg - 1'b1;
                    if (turn_reg == TICKS_W'(1))
                    begin
                        driver_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rx_fill = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
        if (rx_head_next < rx_tail_next)
        begin
            rx_fill = rx_fill + DEPTH_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            sending_reg   <= 1'b0;
            driver_reg    <= 1'b0;
            turn_reg      <= '0;
            ticks_reg     <= TURNAROUND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ticks_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                rx_head_reg   <= rx_head_next;
                rx_tail_reg   <= rx_tail_next;
                tx_head_reg   <= tx_head_next;
                tx_tail_reg   <= tx_tail_next;
                sending_reg   <= sending_next;
                driver_reg    <= driver_next;
                turn_reg      <= turn_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg  <= s_tuser[CMD_W-1:0];
            byte_reg <= s_tdata[DATA_W-1:0];
        end
        if (cmd.exec)
        begin
            out_data_reg <= {3'b000, tx_ovf, rx_ovf, sending_next, driver_next, lb_valid,
                             lb, DATA_W'(rx_fill), rd_data};
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

### design/half_duplex_uart_ring_buffers.sv
// Channel  Handshake             Payload
// -------  --------------------  ------------------------------------------------
// s_*      s_tvalid / s_tready   tdata: data_byte; tuser: command
// m_*      m_tvalid / m_tready   tdata: read_data, rx_fill, line_byte, flags
// cfg_*    cfg_valid / cfg_ready cfg_data: turnaround_ticks
//
// Each item is accepted, then executed, a split that is set by the registered
// read of the ring memories (the tail entry is read during the accept cycle).
// The result lands in an output register; the next item is accepted while it
// waits, and execution stalls only when that register is still occupied.
// Reset clears pointers, flags and countdown; ring contents need no clearing.
// cfg_ready is always high; turnaround_ticks resets to 250.
module half_duplex_uart_ring_buffers #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [7:0]  s_tuser,   // [2:0] command, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [15:8] rx_fill, [23:16] line_byte, [24] line_byte_valid,
    // [25] driver_enable, [26] tx_armed, [27] rx_overflow, [28] tx_overflow
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] turnaround_ticks
);

    import hdurb_pkg::*;

    hdurb_cmd_t  cmd;
    hdurb_stat_t stat;

    // Sequencer: accept, then execute when the result register is free.
    hdurb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Rings, pointers, driver and turnaround countdown, result register.
    hdurb_dp #(.DEPTH(DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    // An executed item always shows up at the output next cycle.
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("executed item did not reach the output register");

    // No item is accepted while one is executing.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted item while another was in flight");

    // Armed transmission implies the driver is on.
    a_armed_driver: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[26]) |-> m_tdata[25])
        else $error("transmission armed with driver released");

    // A dropped received byte means the receive ring is full.
    a_rx_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[27]) |-> (m_tdata[15:8] == 8'(DEPTH - 1)))
        else $error("receive overflow with ring not full");

endmodule

### test/ring_buffer_checker.sv
module ring_buffer_checker #(
    parameter int DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [hdurb_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [hdurb_pkg::S_TUSER_W-1:0] s_tuser,   // [2:0] command, [7:3] zero
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] read_data, [15:8] rx_fill, [23:16] line_byte, [24] line_byte_valid,
    // [25] driver_enable, [26] tx_armed, [27] rx_overflow, [28] tx_overflow
    input  logic [hdurb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hdurb_pkg::TICKS_W-1:0]   cfg_data,  // [15:0] turnaround_ticks
    output int                              errors,
    output int                              outstanding
);

    import hdurb_pkg::*;

    // Same bit layout as m_tdata, highest field first.
    typedef struct packed {
        logic [2:0]        spare;
        logic              tx_overflow;
        logic              rx_overflow;
        logic              tx_armed;
        logic              driver_enable;
        logic              line_byte_valid;
        logic [DATA_W-1:0] line_byte;
        logic [DATA_W-1:0] rx_fill;
        logic [DATA_W-1:0] read_data;
    } ring_status_t;

    logic [DATA_W-1:0]  rx_mem [DEPTH];
    logic [DATA_W-1:0]  tx_mem [DEPTH];
    int unsigned        rx_wr, rx_rd, tx_wr, tx_rd;
    logic               armed, drv_on;
    logic [TICKS_W-1:0] countdown, turnaround;
    ring_status_t       expected_status [$];
    int                 fail_count = 0;

    assign errors = fail_count;

    task automatic advance_ring_model(input logic [CMD_W-1:0] cmd,
                                      input logic [DATA_W-1:0] value,
                                      output ring_status_t st);
        int unsigned nxt;
        st = '0;
        case (cmd)
            CMD_RX_BYTE:
            begin
                nxt = (rx_wr + 1) % DEPTH;
                if (nxt != rx_rd)
                begin
                    rx_mem[rx_wr] = value;
                    rx_wr = nxt;
                end
                else
                    st.rx_overflow = 1'b1;
            end
            CMD_HOST_WRITE:
            begin
                nxt = (tx_wr + 1) % DEPTH;
                if (nxt != tx_rd)
                begin
                    tx_mem[tx_wr] = value;
                    tx_wr = nxt;
                    drv_on = 1'b1;
                    armed = 1'b1;
                    countdown = '0;
                end
                else
                    st.tx_overflow = 1'b1;
            end
            CMD_HOST_READ:
            begin
                if (rx_rd != rx_wr)
                begin
                    st.read_data = rx_mem[rx_rd];
                    rx_rd = (rx_rd + 1) % DEPTH;
                end
            end
            CMD_TX_READY:
            begin
                if (armed)
                begin
                    if (tx_rd != tx_wr)
                    begin
                        st.line_byte = tx_mem[tx_rd];
                        st.line_byte_valid = 1'b1;
                        tx_rd = (tx_rd + 1) % DEPTH;
                    end
                    else
                    begin
                        armed = 1'b0;
                        if (turnaround == '0)
                            drv_on = 1'b0;
                        else
                            countdown = turnaround;
                    end
                end
            end
            CMD_TICK:
            begin
                if (countdown != '0)
                begin
                    countdown = countdown - 1'b1;
                    if (countdown == '0)
                        drv_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        st.rx_fill = DATA_W'((rx_wr + DEPTH - rx_rd) % DEPTH);
        st.driver_enable = drv_on;
        st.tx_armed = armed;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        ring_status_t want;
        ring_status_t got;
        if (!rst_n)
        begin
            rx_wr = 0;
            rx_rd = 0;
            tx_wr = 0;
            tx_rd = 0;
            armed = 1'b0;
            drv_on = 1'b0;
            countdown = '0;
            turnaround = TURNAROUND_RESET;
            expected_status.delete();
            outstanding <= 0;
        end
        else
        begin
            // retire the result first, so a result can never match an item taken this edge
            if (m_tvalid && m_tready)
            begin
                got = ring_status_t'(m_tdata);
                if (expected_status.size() == 0)
                begin
                    fail_count++;
                    $error("result with no item pending: m_tdata %h", m_tdata);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("rx_fill", want.rx_fill, got.rx_fill);
                    check_field("line_byte", want.line_byte, got.line_byte);
                    check_field("line_byte_valid", DATA_W'(want.line_byte_valid),
                                DATA_W'(got.line_byte_valid));
                    check_field("driver_enable", DATA_W'(want.driver_enable),
                                DATA_W'(got.driver_enable));
                    check_field("tx_armed", DATA_W'(want.tx_armed), DATA_W'(got.tx_armed));
                    check_field("rx_overflow", DATA_W'(want.rx_overflow),
                                DATA_W'(got.rx_overflow));
                    check_field("tx_overflow", DATA_W'(want.tx_overflow),
                                DATA_W'(got.tx_overflow));
                end
            end
            if (cfg_valid && cfg_ready)
                turnaround = cfg_data;
            if (s_tvalid && s_tready)
            begin
                advance_ring_model(s_tuser[CMD_W-1:0], s_tdata, want);
                expected_status.push_back(want);
            end
            outstanding <= expected_status.size();
        end
    end

endmodule

### test/tb_half_duplex_uart_ring_buffers.sv
module tb_half_duplex_uart_ring_buffers;
    import hdurb_pkg::*;

    localparam int RING_DEPTH       = 64;
    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 11;
    localparam int MAX_GAP          = 10;
    // long enough for the two-stage pipe to fill and push back on s_tready
    localparam int LONG_HOLD_CYCLES = 160;
    // covers accept, execute and the output register with margin
    localparam int DRAIN_CYCLES     = 8;
    localparam int PHASE_ITEMS      = 35;
    localparam int TIMEOUT_CYCLES   = 300000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [7:0] data_byte
    logic [S_TUSER_W-1:0] s_tuser = '0;   // [2:0] command, [7:3] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] read_data, [15:8] rx_fill, [23:16] line_byte, [24] line_byte_valid,
    // [25] driver_enable, [26] tx_armed, [27] rx_overflow, [28] tx_overflow
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TICKS_W-1:0]   cfg_data = '0;  // [15:0] turnaround_ticks

    int errors;
    int outstanding;
    int items_sent = 0;
    // written by the stimulus only; the result sink counts what it has served
    int hold_requests = 0;
    bit sender_fast = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    half_duplex_uart_ring_buffers #(
        .DEPTH (RING_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ring_buffer_checker #(
        .DEPTH (RING_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Offer one item and hold it until the block takes it. Keep tvalid high
    // across back-to-back items; drop it only when a gap is drawn.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] value);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            sender_fast = !sender_fast;
        gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser <= S_TUSER_W'(cmd);
        s_tdata <= value;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result is back, then let
    // the pipe settle before touching the register.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_turnaround(input logic [TICKS_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed stretch of traffic with random content, or a little noise.
    task automatic random_burst();
        int unsigned kind, len, i;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // receive side: line bytes mixed with host reads, fill drifts upward
            len = $urandom_range(1, 24);
            for (i = 0; i < len; i++)
                send_item(($urandom_range(0, 99) < 55) ? CMD_RX_BYTE : CMD_HOST_READ,
                          8'($urandom));
        end
        else if (kind < 8)
        begin
            // transmit side: queue a message, drain it, then run the turnaround;
            // a following burst may land inside the countdown and cancel it
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++)
                send_item(CMD_HOST_WRITE, 8'($urandom));
            len = len + $urandom_range(0, 2);
            for (i = 0; i < len; i++)
                send_item(CMD_TX_READY, 8'($urandom));
            len = $urandom_range(0, 12);
            for (i = 0; i < len; i++)
                send_item(CMD_TICK, 8'($urandom));
        end
        else
        begin
            // noise: any command code, spare ones included
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                send_item(CMD_W'($urandom), 8'($urandom));
        end
    endtask

    // Result sink: draw a stall per result, flip into no-stall stretches now
    // and then, and serve a long hold-off whenever the stimulus asks for one.
    initial
    begin : result_sink
        int unsigned gap;
        int holds_served;
        bit fast;
        holds_served = 0;
        fast = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_requests > holds_served)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            if ($urandom_range(0, 31) == 0)
                fast = !fast;
            gap = fast ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        int unsigned n, target, i;
        logic [TICKS_W-1:0] settings [4];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, turnaround still at its reset value.
        send_item(CMD_RX_BYTE, 8'h00);
        send_item(CMD_RX_BYTE, 8'hFF);
        send_item(CMD_HOST_READ, 8'hFF);
        send_item(CMD_HOST_READ, 8'h00);
        // read with the receive ring empty
        send_item(CMD_HOST_READ, 8'hFF);
        // ready while disarmed, tick with no countdown running
        send_item(CMD_TX_READY, 8'hFF);
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_HOST_WRITE, 8'hFF);
        send_item(CMD_HOST_WRITE, 8'h00);
        send_item(CMD_TX_READY, 8'h00);
        send_item(CMD_TX_READY, 8'hFF);
        // ring empty while armed: disarm and load the countdown
        send_item(CMD_TX_READY, 8'h00);
        send_item(CMD_TICK, 8'h00);
        // host write inside the countdown: cancel it, keep the driver on
        send_item(CMD_HOST_WRITE, 8'hA5);
        send_item(CMD_TX_READY, 8'h5A);
        send_item(CMD_TX_READY, 8'h00);
        // spare command codes change nothing
        for (int c = int'(CMD_TICK) + 1; c < (1 << CMD_W); c++)
            send_item(CMD_W'(c), 8'hFF);

        // Zero turnaround: release the driver on the disarming ready.
        wait_drained();
        write_turnaround('0);
        send_item(CMD_HOST_WRITE, 8'h3C);
        send_item(CMD_TX_READY, 8'h00);
        send_item(CMD_TX_READY, 8'h00);
        send_item(CMD_TICK, 8'h00);

        // Fill both rings past full. Ask the sink for a long hold-off while
        // the line bytes stream in back to back, so s_tready has to drop.
        wait_drained();
        write_turnaround(TICKS_W'(3));
        hold_requests++;
        sender_fast = 1'b1;
        n = RING_DEPTH - 1 + $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            send_item(CMD_RX_BYTE, 8'($urandom));
        // one read more than the ring holds, so the last one finds it empty
        for (i = 0; i < RING_DEPTH; i++)
            send_item(CMD_HOST_READ, 8'($urandom));
        n = RING_DEPTH - 1 + $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            send_item(CMD_HOST_WRITE, 8'($urandom));
        // every queued byte plus the disarming ready
        for (i = 0; i < RING_DEPTH; i++)
            send_item(CMD_TX_READY, 8'($urandom));
        // count the turnaround down to release, plus one idle tick
        for (i = 0; i < 4; i++)
            send_item(CMD_TICK, 8'($urandom));

        // Random phases, each under its own turnaround setting.
        settings[0] = '1;
        settings[1] = TICKS_W'(1);
        settings[2] = TICKS_W'($urandom_range(2, 12));
        settings[3] = TICKS_W'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            write_turnaround(settings[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_burst();
        end

        wait_drained();
        if (errors == 0 && outstanding == 0)
            $display("tb_half_duplex_uart_ring_buffers: clean");
        else
            $display("tb_half_duplex_uart_ring_buffers: errors");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("tb_half_duplex_uart_ring_buffers: errors");
        $finish;
    end

endmodule
